[design/prm_pkg.sv]
// prm_pkg: shared constants, codes and helpers for the polygon region mask
// no dependencies; used by prm_div, polygon_region_mask, prm_checker and tb_top
package prm_pkg;

  localparam int MAX_VERTICES    = 128;
  localparam int COORD_FRAC_BITS = 4;

  localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  // arithmetic widths
  localparam int DIF_W = 17;            // difference of two coordinates
  localparam int PRD_W = 2 * DIF_W;     // product of two differences
  localparam int ACC_W = PRD_W + 1;     // sum of two products
  localparam int QUO_W = 18;            // crossing offset, bounded by one edge span
  localparam int MAG_W = PRD_W - 1;     // magnitude of a product

  localparam logic signed [15:0] COORD_MAX = 16'sh7fff;
  localparam logic signed [15:0] COORD_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEST   = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_FEW  = 2'd2,
    ST_RSVD = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_KEEP_INSIDE = 2'd0,
    REG_FILL_VALUE  = 2'd1,
    REG_RAY_END_X   = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_t;

  // a - b, sign extended to a coordinate difference
  function automatic logic signed [DIF_W-1:0] sub17(input logic signed [15:0] a,
                                                    input logic signed [15:0] b);
    logic signed [DIF_W-1:0] ea;
    logic signed [DIF_W-1:0] eb;
    ea = DIF_W'(a);
    eb = DIF_W'(b);
    return ea - eb;
  endfunction

endpackage

[design/prm_div.sv]
// prm_div: iterative restoring signed divider, one quotient bit per cycle
// truncates toward zero; depends on prm_pkg
module prm_div import prm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [PRD_W-1:0] num,
  input  logic signed [DIF_W-1:0] den,
  output logic                    done,
  output logic signed [QUO_W-1:0] quo
);

  localparam int STEP_W = $clog2(MAG_W + 1);

  logic [MAG_W-1:0]  dvd_r, dvd_nxt;
  logic [DIF_W-1:0]  rem_r, rem_nxt;
  logic [DIF_W-1:0]  dmag_r;
  logic              neg_r;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;

  logic [PRD_W-1:0]  num_abs;
  logic [DIF_W-1:0]  den_abs;
  logic [DIF_W-1:0]  shifted;
  logic              fits;

  assign num_abs = num[PRD_W-1] ? PRD_W'(-num) : PRD_W'(num);
  assign den_abs = den[DIF_W-1] ? DIF_W'(-den) : DIF_W'(den);
  assign shifted = {rem_r[DIF_W-2:0], dvd_r[MAG_W-1]};
  assign fits    = (shifted >= dmag_r);

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt = num_abs[MAG_W-1:0];
      rem_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = fits ? shifted - dmag_r : shifted;
      dvd_nxt = {dvd_r[MAG_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == STEP_W'(MAG_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dmag_r <= den_abs;
      neg_r  <= num[PRD_W-1] ^ den[DIF_W-1];
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? QUO_W'(-$signed({1'b0, dvd_r})) : QUO_W'($signed({1'b0, dvd_r}));

endmodule

[design/polygon_region_mask.sv]
// polygon_region_mask: top level, vertex store, sequencer and shared multiplier
// depends on prm_pkg and prm_div
//
// Point-in-polygon region mask. Vertices (cmd 0 starts a polygon, cmd 1
// appends) are stored in a MAX_VERTICES deep memory and the bounding box is
// tracked. A test (cmd 2) whose point lies in the box walks every stored
// vertex with one sequencer: four memory reads (current, next, previous,
// next but one), then a crossing division (one shared 17x17 multiply, then
// a 33-step bit-serial divide that is waited on), a vertex side check (four
// multiplies on the shared multiplier) or neither. A test whose point lies
// on a horizontal edge stops at that edge, and tests that fall outside the
// box or have fewer than three vertices are answered without a walk. The
// block takes one transaction at a time: in_stall stays high until the
// result is in the output register and has left it. The configuration port
// is APB-like with pready always high; registers sit at byte addresses 0
// (keep_inside), 4 (fill_value) and 8 (ray_end_x); they are to be written
// only while the block is idle, which the block itself does not enforce.
module polygon_region_mask import prm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic signed [15:0] in_coord_x,
  input  logic signed [15:0] in_coord_y,
  input  logic signed [15:0] in_sample,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_inside_flag,
  output logic signed [15:0] out_masked_sample,
  output logic signed [15:0] out_run_end_x,
  output logic [1:0]         out_status,
  // configuration port
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_RDC   = 12'b000000000010,
    S_RDN   = 12'b000000000100,
    S_RDP   = 12'b000000001000,
    S_RDQ   = 12'b000000010000,
    S_EVAL  = 12'b000000100000,
    S_CROSS = 12'b000001000000,
    S_MULN  = 12'b000010000000,
    S_DIVGO = 12'b000100000000,
    S_DIVW  = 12'b001000000000,
    S_ADV   = 12'b010000000000,
    S_FIN   = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic               keep_inside_r;
  logic signed [15:0] fill_value_r;
  logic signed [15:0] ray_end_x_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  // vertex store and box
  logic signed [15:0] vx_mem [MAX_VERTICES];
  logic signed [15:0] vy_mem [MAX_VERTICES];
  logic [CNT_W-1:0]   vcount_r;
  logic signed [15:0] bmin_x_r, bmax_x_r, bmin_y_r, bmax_y_r;

  // read port
  logic [IDX_W-1:0]   raddr;
  logic               rd_en;
  logic signed [15:0] rd_x_r, rd_y_r;

  // test point and walk state
  logic signed [15:0] tx_r, ty_r, smp_r;
  logic [IDX_W-1:0]   ci_r;
  logic [CNT_W:0]     i_r;
  logic signed [15:0] cx_r, cy_r, nxx_r, nxy_r, pvx_r, pvy_r;
  logic signed [15:0] lim_r;
  logic               par_r;
  logic               skip2_r;
  logic               sel_vert_r;
  logic [2:0]         k_r;
  logic               c1_pos_r, c1_neg_r;

  // shared multiplier
  logic signed [DIF_W-1:0] mul_a, mul_b;
  logic signed [PRD_W-1:0] mul_p;
  logic signed [PRD_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_sum;

  // divider
  logic                    div_done;
  logic signed [QUO_W-1:0] div_quo;

  // output register
  logic               out_valid_r;
  logic               o_flag_r;
  logic signed [15:0] o_masked_r, o_run_r;
  logic [1:0]         o_status_r;

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;
  assign in_stall = (state_r != S_IDLE) || out_valid_r;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_inside_r <= 1'b1;
      fill_value_r  <= -16'sd1;
      ray_end_x_r   <= COORD_MAX;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_KEEP_INSIDE: keep_inside_r <= cfg_pwdata[0];
        REG_FILL_VALUE:  fill_value_r  <= cfg_pwdata[15:0];
        REG_RAY_END_X:   ray_end_x_r   <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_KEEP_INSIDE: cfg_prdata = {31'd0, keep_inside_r};
      REG_FILL_VALUE:  cfg_prdata = {{16{fill_value_r[15]}}, fill_value_r};
      REG_RAY_END_X:   cfg_prdata = {{16{ray_end_x_r[15]}}, ray_end_x_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- store
  logic               is_load, is_start, load_ok;
  logic [IDX_W-1:0]   waddr;
  assign is_load  = in_acc && (in_cmd == CMD_START || in_cmd == CMD_APPEND);
  assign is_start = in_cmd == CMD_START;
  // a start always has room, an append only below the store depth
  assign load_ok  = is_start || (vcount_r < CNT_W'(MAX_VERTICES));
  assign waddr    = is_start ? '0 : vcount_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (is_load && load_ok) begin
      vx_mem[waddr] <= in_coord_x;
      vy_mem[waddr] <= in_coord_y;
    end
    if (rd_en) begin
      rd_x_r <= vx_mem[raddr];
      rd_y_r <= vy_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
      bmin_x_r <= COORD_MAX;
      bmin_y_r <= COORD_MAX;
      bmax_x_r <= COORD_MIN;
      bmax_y_r <= COORD_MIN;
    end else if (is_load) begin
      if (is_start) begin
        vcount_r <= CNT_W'(1);
        bmin_x_r <= in_coord_x;
        bmax_x_r <= in_coord_x;
        bmin_y_r <= in_coord_y;
        bmax_y_r <= in_coord_y;
      end else if (load_ok) begin
        vcount_r <= vcount_r + 1'b1;
        if (in_coord_x < bmin_x_r) bmin_x_r <= in_coord_x;
        if (in_coord_x > bmax_x_r) bmax_x_r <= in_coord_x;
        if (in_coord_y < bmin_y_r) bmin_y_r <= in_coord_y;
        if (in_coord_y > bmax_y_r) bmax_y_r <= in_coord_y;
      end
    end
  end

  // ---------------------------------------------------------------- indexes
  logic [IDX_W-1:0] nm1, nx_idx, pv_idx, nn_idx;
  assign nm1    = IDX_W'(vcount_r - 1'b1);
  assign nx_idx = (ci_r == nm1) ? '0 : ci_r + 1'b1;
  assign pv_idx = (ci_r == '0) ? nm1 : ci_r - 1'b1;
  assign nn_idx = (nx_idx == nm1) ? '0 : nx_idx + 1'b1;

  assign rd_en = (state_r == S_RDC) || (state_r == S_RDN) ||
                 (state_r == S_RDP) || (state_r == S_RDQ);

  always_comb begin
    unique case (state_r)
      S_RDN:   raddr = nx_idx;
      S_RDP:   raddr = pv_idx;
      S_RDQ:   raddr = nn_idx;
      default: raddr = ci_r;
    endcase
  end

  // default limit: right box edge plus one unit, saturated
  logic signed [16:0] lim_sum;
  logic signed [15:0] def_lim;
  assign lim_sum = 17'(bmax_x_r) + 17'sd1 * (17'sd1 <<< COORD_FRAC_BITS);
  assign def_lim = (lim_sum > 17'(COORD_MAX)) ? COORD_MAX : lim_sum[15:0];

  logic in_box;
  assign in_box = !(in_coord_x < bmin_x_r || in_coord_x > bmax_x_r ||
                    in_coord_y < bmin_y_r || in_coord_y > bmax_y_r);

  // ---------------------------------------------------------------- evaluate
  logic               on_c, on_n, straddle, on_edge;
  logic signed [15:0] lo_x, hi_x;
  assign on_c     = cy_r == ty_r;
  assign on_n     = nxy_r == ty_r;
  assign lo_x     = (cx_r < nxx_r) ? cx_r : nxx_r;
  assign hi_x     = (cx_r < nxx_r) ? nxx_r : cx_r;
  assign on_edge  = on_c && on_n && tx_r >= lo_x && tx_r <= hi_x;
  assign straddle = (cy_r < ty_r && pvy_r > ty_r) || (cy_r > ty_r && pvy_r < ty_r);

  // shared multiplier operand selection; the side check uses the edge pairs
  // (prev, cur) and (next, next2) on a horizontal edge, (prev, cur) and
  // (cur, next) at a single vertex on the ray
  logic signed [15:0] ax, ay, bx, by, ccx, ccy, dx, dy;
  assign ax  = pvx_r;
  assign ay  = pvy_r;
  assign bx  = cx_r;
  assign by  = cy_r;
  assign ccx = sel_vert_r ? cx_r  : nxx_r;
  assign ccy = sel_vert_r ? cy_r  : nxy_r;
  assign dx  = sel_vert_r ? nxx_r : rd_x_r;
  assign dy  = sel_vert_r ? nxy_r : rd_y_r;

  always_comb begin
    if (state_r == S_CROSS) begin
      case (k_r[2:1])
        2'd0:    begin mul_a = sub17(ray_end_x_r, ax);  mul_b = sub17(ty_r, by); end
        2'd1:    begin mul_a = sub17(ty_r, ay);         mul_b = sub17(ray_end_x_r, bx); end
        2'd2:    begin mul_a = sub17(ray_end_x_r, ccx); mul_b = sub17(ty_r, dy); end
        default: begin mul_a = sub17(ty_r, ccy);        mul_b = sub17(ray_end_x_r, dx); end
      endcase
    end else begin
      mul_a = sub17(ty_r, cy_r);
      mul_b = sub17(pvx_r, cx_r);
    end
  end
  assign mul_p   = mul_a * mul_b;
  assign acc_sum = acc_r + ACC_W'(prod_r);

  prm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_DIVGO),
    .num   (prod_r),
    .den   (sub17(pvy_r, cy_r)),
    .done  (div_done),
    .quo   (div_quo)
  );

  logic signed [QUO_W-1:0] xq;
  assign xq = QUO_W'(cx_r) + div_quo;

  logic c2_pos, c2_neg, opp;
  assign c2_pos = acc_sum > 0;
  assign c2_neg = acc_sum < 0;
  assign opp    = (c1_pos_r && c2_pos) || (c1_neg_r && c2_neg);

  logic [CNT_W:0] i_step;
  assign i_step = i_r + (skip2_r ? (CNT_W+1)'(2) : (CNT_W+1)'(1));

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && in_cmd == CMD_TEST && vcount_r >= CNT_W'(3) && in_box)
                 state_nxt = S_RDC;
      S_RDC:   state_nxt = S_RDN;
      S_RDN:   state_nxt = S_RDP;
      S_RDP:   state_nxt = S_RDQ;
      S_RDQ:   state_nxt = S_EVAL;
      S_EVAL: begin
        if (on_edge)                          state_nxt = S_FIN;
        else if (on_c && on_n)                state_nxt = (cx_r > tx_r) ? S_CROSS : S_ADV;
        else if (on_c)                        state_nxt = (cx_r > tx_r) ? S_CROSS : S_ADV;
        else if (straddle)                    state_nxt = S_MULN;
        else                                  state_nxt = S_ADV;
      end
      S_CROSS: if (k_r == 3'd7) state_nxt = S_ADV;
      S_MULN:  state_nxt = S_DIVGO;
      S_DIVGO: state_nxt = S_DIVW;
      S_DIVW:  if (div_done) state_nxt = S_ADV;
      S_ADV:   state_nxt = (i_step > (CNT_W+1)'(vcount_r)) ? S_FIN : S_RDC;
      S_FIN:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // walk datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (state_r == S_CROSS) begin
      k_r <= k_r + 1'b1;
    end else begin
      k_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          tx_r  <= in_coord_x;
          ty_r  <= in_coord_y;
          smp_r <= in_sample;
        end
        ci_r  <= '0;
        i_r   <= (CNT_W+1)'(1);
        lim_r <= def_lim;
        par_r <= 1'b0;
      end
      S_RDN: begin cx_r  <= rd_x_r; cy_r  <= rd_y_r; end
      S_RDP: begin nxx_r <= rd_x_r; nxy_r <= rd_y_r; end
      S_RDQ: begin pvx_r <= rd_x_r; pvy_r <= rd_y_r; end
      S_EVAL: begin
        skip2_r <= on_c && on_n;
        if (on_edge) begin
          // point on a horizontal edge: inside, run ends at its right end
          par_r <= 1'b1;
          lim_r <= hi_x;
        end else if (on_c && on_n) begin
          sel_vert_r <= 1'b0;
          if (cx_r > tx_r && lo_x < lim_r) lim_r <= lo_x;
        end else if (on_c) begin
          sel_vert_r <= 1'b1;
          if (cx_r > tx_r && cx_r < lim_r) lim_r <= cx_r;
        end
      end
      S_CROSS: begin
        if (!k_r[0]) begin
          prod_r <= mul_p;
        end else begin
          case (k_r[2:1]) inside
            2'd0, 2'd2: acc_r <= -ACC_W'(prod_r);
            2'd1: begin
              c1_pos_r <= acc_sum > 0;
              c1_neg_r <= acc_sum < 0;
            end
            default: par_r <= par_r ^ opp;
          endcase
        end
      end
      S_MULN: prod_r <= mul_p;
      S_DIVW: begin
        if (div_done && xq > QUO_W'(tx_r)) begin
          par_r <= ~par_r;
          if (xq < QUO_W'(lim_r)) lim_r <= xq[15:0];
        end
      end
      S_ADV: begin
        i_r  <= i_step;
        ci_r <= skip2_r ? nn_idx : nx_idx;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- results
  logic               res_en;
  logic               res_flag;
  logic signed [15:0] res_run;
  logic [1:0]         res_status;
  logic               res_masks;

  always_comb begin
    res_en     = 1'b0;
    res_flag   = 1'b0;
    res_run    = '0;
    res_status = ST_OK;
    res_masks  = 1'b0;
    if (state_r == S_FIN) begin
      res_en    = 1'b1;
      res_flag  = par_r;
      res_run   = lim_r;
      res_masks = 1'b1;
    end else if (in_acc) begin
      unique case (cmd_t'(in_cmd)) inside
        CMD_START, CMD_APPEND: begin
          res_en     = 1'b1;
          res_status = load_ok ? ST_OK : ST_FULL;
        end
        CMD_TEST: begin
          if (vcount_r < CNT_W'(3)) begin
            res_en     = 1'b1;
            res_status = ST_FEW;
            res_masks  = 1'b1;
          end else if (!in_box) begin
            res_en    = 1'b1;
            res_run   = def_lim;
            res_masks = 1'b1;
          end
        end
        default: res_en = 1'b1;
      endcase
    end
  end

  logic signed [15:0] res_smp;
  logic signed [15:0] res_masked;
  assign res_smp    = (state_r == S_FIN) ? smp_r : in_sample;
  assign res_masked = !res_masks ? 16'sd0 :
                      (keep_inside_r == res_flag) ? res_smp : fill_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_en) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_en) begin
      o_flag_r   <= res_flag;
      o_masked_r <= res_masked;
      o_run_r    <= res_run;
      o_status_r <= res_status;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_inside_flag   = o_flag_r;
  assign out_masked_sample = o_masked_r;
  assign out_run_end_x     = o_run_r;
  assign out_status        = o_status_r;

  // ---------------------------------------------------------------- checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (out_valid_r || state_r != S_IDLE))
    else $error("accepted transaction produced neither result nor walk");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vcount_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond store depth");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIVW)
    else $error("divider finished outside its wait state");

  a_walk_needs_vertices: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RDC |-> vcount_r >= CNT_W'(3))
    else $error("walk started with too few vertices");

endmodule

[tb/prm_checker.sv]
`timescale 1ns / 1ps
// prm_checker: watches both channels of polygon_region_mask, predicts each result
// depends on prm_pkg; instantiated by tb_top, reports an error count
module prm_checker import prm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic signed [15:0] in_coord_x,
  input  logic signed [15:0] in_coord_y,
  input  logic signed [15:0] in_sample,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_inside_flag,
  input  logic signed [15:0] out_masked_sample,
  input  logic signed [15:0] out_run_end_x,
  input  logic [1:0]         out_status,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic               cfg_pready,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output int                 err_count,
  output int                 pending
);

  typedef struct packed {
    logic               in_poly;
    logic signed [15:0] masked;
    logic signed [15:0] run_end;
    logic [1:0]         status;
  } mask_result_t;

  mask_result_t result_q[$];

  int vx[MAX_VERTICES];
  int vy[MAX_VERTICES];
  int nverts;
  int bmin_x, bmax_x, bmin_y, bmax_y;
  logic keep_in;
  int fill_v, ray_x;

  assign pending = result_q.size();

  function automatic int cyc(int j);
    return (j + nverts - 1) % nverts;
  endfunction

  function automatic longint end_cross(int ey, int a, int b);
    longint dxa, dya, dxb, dyb;
    dxa = longint'(ray_x) - vx[a];
    dya = longint'(ey) - vy[a];
    dxb = longint'(ray_x) - vx[b];
    dyb = longint'(ey) - vy[b];
    return -dxa * dyb + dya * dxb;
  endfunction

  function automatic bit same_side(int ey, int a, int b, int c, int d);
    longint c1, c2;
    c1 = end_cross(ey, a, b);
    c2 = end_cross(ey, c, d);
    return (c1 > 0 && c2 > 0) || (c1 < 0 && c2 < 0);
  endfunction

  // crossing-number walk over the stored outline
  function automatic bit ray_parity(int tx, int ty, output int lim);
    int limit, cnt, i, c, nx, pv, cx, cy, nxx, lo, hi, px, py, x;
    longint num, den;
    limit = bmax_x + (1 << COORD_FRAC_BITS);
    if (limit > 32767) limit = 32767;
    cnt = 0;
    for (i = 1; i <= nverts; i++) begin
      c = cyc(i); nx = cyc(i + 1); pv = cyc(i - 1);
      cx = vx[c]; cy = vy[c];
      if (cy == ty) begin
        nxx = vx[nx];
        if (vy[nx] == ty) begin
          lo = cx < nxx ? cx : nxx;
          hi = cx < nxx ? nxx : cx;
          if (tx >= lo && tx <= hi) begin
            lim = hi;
            return 1'b1;
          end
          if (cx > tx) begin
            if (same_side(ty, pv, c, nx, cyc(i + 2))) cnt++;
            if (lo < limit) limit = lo;
          end
          i++;
        end else if (cx > tx) begin
          if (same_side(ty, pv, c, c, nx)) cnt++;
          if (cx < limit) limit = cx;
        end
      end else begin
        px = vx[pv]; py = vy[pv];
        if ((cy < ty && py > ty) || (cy > ty && py < ty)) begin
          num = (longint'(ty) - cy) * (longint'(px) - cx);
          den = longint'(py) - cy;
          x = int'(longint'(cx) + num / den);
          if (x > tx) begin
            cnt++;
            if (x < limit) limit = x;
          end
        end
      end
    end
    lim = limit;
    return cnt[0];
  endfunction

  function automatic mask_result_t predict_mask(logic [1:0] cmd, int x, int y, int s);
    mask_result_t r;
    int run;
    bit flag;
    r = '0;
    flag = 0;
    run = 0;
    if (cmd == CMD_START || cmd == CMD_APPEND) begin
      if (cmd == CMD_START) begin
        nverts = 0;
        bmin_x = x; bmax_x = x; bmin_y = y; bmax_y = y;
      end
      if (nverts < MAX_VERTICES) begin
        vx[nverts] = x; vy[nverts] = y; nverts++;
        if (x < bmin_x) bmin_x = x;
        if (x > bmax_x) bmax_x = x;
        if (y < bmin_y) bmin_y = y;
        if (y > bmax_y) bmax_y = y;
      end else begin
        r.status = ST_FULL;
      end
      return r;
    end
    if (cmd != CMD_TEST) return r;
    if (nverts < 3) begin
      r.status = ST_FEW;
    end else if (x < bmin_x || x > bmax_x || y < bmin_y || y > bmax_y) begin
      run = bmax_x + (1 << COORD_FRAC_BITS);
      if (run > 32767) run = 32767;
    end else begin
      flag = ray_parity(x, y, run);
    end
    r.in_poly = flag;
    r.run_end = 16'(run);
    if (keep_in) r.masked = flag ? 16'(s) : 16'(fill_v);
    else r.masked = flag ? 16'(fill_v) : 16'(s);
    return r;
  endfunction

  always @(posedge clk) begin
    mask_result_t want;
    if (!rst_n) begin
      nverts = 0;
      bmin_x = 32767; bmin_y = 32767; bmax_x = -32768; bmax_y = -32768;
      keep_in = 1'b1; fill_v = -1; ray_x = 32767;
      err_count = 0;
      result_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[3:2]))
          REG_KEEP_INSIDE: keep_in = cfg_pwdata[0];
          REG_FILL_VALUE:  fill_v = int'($signed(cfg_pwdata[15:0]));
          REG_RAY_END_X:   ray_x = int'($signed(cfg_pwdata[15:0]));
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $error("result with nothing expected");
          err_count++;
        end else begin
          want = result_q.pop_front();
          if (out_inside_flag !== want.in_poly) begin
            $error("inside_flag exp %0d got %0d", want.in_poly, out_inside_flag);
            err_count++;
          end
          if (out_masked_sample !== want.masked) begin
            $error("masked_sample exp %0d got %0d", want.masked, out_masked_sample);
            err_count++;
          end
          if (out_run_end_x !== want.run_end) begin
            $error("run_end_x exp %0d got %0d", want.run_end, out_run_end_x);
            err_count++;
          end
          if (out_status !== want.status) begin
            $error("status exp %0d got %0d", want.status, out_status);
            err_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        result_q.push_back(predict_mask(in_cmd, in_coord_x, in_coord_y, in_sample));
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for polygon_region_mask
// depends on prm_pkg, prm_checker and the design
module tb_top;
  import prm_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [1:0] in_cmd;
  logic signed [15:0] in_coord_x, in_coord_y, in_sample;
  logic out_valid, out_stall, out_inside_flag;
  logic signed [15:0] out_masked_sample, out_run_end_x;
  logic [1:0] out_status;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [3:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  int err_count, pending;
  int idle_cycles;
  bit drain_phase;   // no receiver stalls near the end

  polygon_region_mask dut (.*);
  prm_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver side: random stall bursts, none in the final phase
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!drain_phase && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 15);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 200000) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // send one transaction and hold it until accepted
  task automatic send_item(logic [1:0] cmd, logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] s);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_coord_x <= x;
    in_coord_y <= y;
    in_sample <= s;
    do @(posedge clk); while (!(in_valid && !in_stall));
    // random sender gap bursts
    if (!drain_phase && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // wait for all results, then let the block settle before touching registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  function automatic logic signed [15:0] rnd16();
    return 16'($urandom);
  endfunction

  // random polygon: small ones mostly, vertices near a center to get hits
  task automatic load_polygon(int nv, int cx, int cy, int spread);
    for (int i = 0; i < nv; i++)
      send_item(i == 0 ? CMD_START : CMD_APPEND,
                16'(cx + $urandom_range(0, 2 * spread) - spread),
                16'(cy + $urandom_range(0, 2 * spread) - spread), rnd16());
  endtask

  initial begin
    int cx, cy, spread, nv;
    in_valid = 1'b0; in_cmd = CMD_TEST;
    in_coord_x = '0; in_coord_y = '0; in_sample = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    drain_phase = 1'b0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: too few vertices, reserved command, extremes
    send_item(CMD_TEST, 16'sd0, 16'sd0, 16'sd5);
    send_item(CMD_RSVD, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_item(CMD_START, 16'sd0, 16'sd0, 16'sd0);
    send_item(CMD_APPEND, 16'sd160, 16'sd0, 16'sd0);
    send_item(CMD_TEST, 16'sd10, 16'sd10, 16'sd7);       // two vertices only
    send_item(CMD_APPEND, 16'sd160, 16'sd160, 16'sd0);
    send_item(CMD_APPEND, 16'sd0, 16'sd160, 16'sd0);
    send_item(CMD_TEST, 16'sd80, 16'sd80, 16'sh7fff);     // inside
    send_item(CMD_TEST, 16'sd80, 16'sd0, 16'sh8000);      // on horizontal edge
    send_item(CMD_TEST, 16'sd0, 16'sd80, 16'sd3);         // on vertical edge
    send_item(CMD_TEST, 16'sd200, 16'sd80, 16'sd3);       // outside the box
    send_item(CMD_TEST, 16'sh8000, 16'sh7fff, 16'sd3);
    // vertex on the ray: diamond
    send_item(CMD_START, 16'sd0, 16'sd0, 16'sd0);
    send_item(CMD_APPEND, 16'sd64, 16'sd64, 16'sd0);
    send_item(CMD_APPEND, 16'sd128, 16'sd0, 16'sd0);
    send_item(CMD_APPEND, 16'sd64, -16'sd64, 16'sd0);
    send_item(CMD_TEST, 16'sd10, 16'sd0, 16'sd1);
    send_item(CMD_TEST, -16'sd10, 16'sd0, 16'sd1);
    // box at the top coordinate limit, saturated default limit
    send_item(CMD_START, 16'sh7fff, 16'sh7fff, 16'sd0);
    send_item(CMD_APPEND, 16'sh8000, 16'sh7fff, 16'sd0);
    send_item(CMD_APPEND, 16'sd0, 16'sh8000, 16'sd0);
    send_item(CMD_TEST, 16'sd5, 16'sd5, 16'sd9);
    send_item(CMD_TEST, 16'sh7ff0, 16'sd5, 16'sd9);

    // full store: one polygon of the largest size, dropped appends
    wait_idle();
    write_reg(REG_KEEP_INSIDE, 32'd0);
    write_reg(REG_FILL_VALUE, 32'h0000_8000);
    write_reg(REG_RAY_END_X, 32'h0000_8000);
    load_polygon(MAX_VERTICES, 0, 0, 2000);
    send_item(CMD_APPEND, 16'sd1, 16'sd1, 16'sd0);
    send_item(CMD_APPEND, 16'sd2, 16'sd2, 16'sd0);
    send_item(CMD_TEST, 16'sd0, 16'sd0, 16'sd4);
    send_item(CMD_TEST, 16'sd100, -16'sd100, 16'sd4);

    // random phases under several register settings
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();   // sender holds off until every result is back
      write_reg(REG_KEEP_INSIDE, 32'($urandom_range(0, 1)));
      write_reg(REG_FILL_VALUE, ph == 1 ? 32'h7fff : $urandom);
      write_reg(REG_RAY_END_X, ph == 2 ? 32'h7fff : (ph == 3 ? 32'h8000 : $urandom));
      if (ph == 5) drain_phase = 1'b1;
      for (int p = 0; p < 4; p++) begin
        nv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
        spread = $urandom_range(0, 3) == 0 ? 30000 : $urandom_range(4, 300);
        cx = $urandom_range(0, 1) ? 0 : $signed(16'($urandom)) / 2;
        cy = $signed(16'($urandom)) / 2;
        if (nv == 0) send_item(CMD_START, rnd16(), rnd16(), rnd16());
        else load_polygon(nv, cx, cy, spread);
        for (int t = 0; t < 6; t++) begin
          case ($urandom_range(0, 9))
            0: send_item(2'($urandom), rnd16(), rnd16(), rnd16());   // noise
            1: send_item(CMD_TEST, rnd16(), rnd16(), rnd16());
            default: send_item(CMD_TEST,
                               16'(cx + $urandom_range(0, 2 * spread) - spread),
                               16'(cy + $urandom_range(0, 2 * spread) - spread), rnd16());
          endcase
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (err_count == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule
